[src/i2a_pkg.sv]
// Shared types and constants for the integer to ASCII formatter.
// Holds the beat structs, selector codes, character codes and the digit unit control.
// No dependencies.
`default_nettype none

package i2a_pkg;

  // selector codes
  localparam logic [2:0] FUNC_UDEC32 = 3'd0;
  localparam logic [2:0] FUNC_UDEC64 = 3'd1;
  localparam logic [2:0] FUNC_SDEC32 = 3'd2;
  localparam logic [2:0] FUNC_SDEC64 = 3'd3;
  localparam logic [2:0] FUNC_HEX32  = 3'd4;
  localparam logic [2:0] FUNC_HEX64  = 3'd5;
  localparam logic [2:0] FUNC_PTR    = 3'd6;
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_F     = 7'h66;
  localparam logic [6:0] CHAR_X     = 7'h78;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;

  // digit register geometry
  localparam int unsigned DigitSlots = 20;
  localparam int unsigned DigitBits  = 4 * DigitSlots;
  localparam int unsigned BitsPerStep = 4;
  localparam logic [4:0] DEC_DIGITS = 5'd20;
  localparam logic [4:0] HEX_DIGITS = 5'd16;
  localparam logic [3:0] CONV_LAST  = 4'd15;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  func;
  } in_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last;
  } out_t;

  // control from the sequencer to the digit unit
  typedef struct packed {
    logic load;
    logic hex;
    logic conv;
    logic shift;
  } dig_ctrl_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CONV  = 7'b0000010,
    ST_SKIP  = 7'b0000100,
    ST_PFX0  = 7'b0001000,
    ST_PFXX  = 7'b0010000,
    ST_MINUS = 7'b0100000,
    ST_DIGIT = 7'b1000000
  } state_e;

  // one nibble to its lowercase character
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/i2a_digits.sv]
// Digit unit of the integer to ASCII formatter: a shared shift-and-correct
// binary to BCD converter and the digit register that feeds the character output.
// Depends on i2a_pkg.
`default_nettype none

module i2a_digits (
  input  wire logic              clk_i,
  input  wire i2a_pkg::dig_ctrl_t ctrl_i,
  input  wire logic [63:0]       mag_i,
  output logic [3:0]             top_digit_o
);
  import i2a_pkg::*;

  logic [DigitBits-1:0] dig_q, dig_d;
  logic [63:0]          bin_q, bin_d;

  // four add-3-and-shift steps of the binary to BCD conversion
  function automatic logic [DigitBits-1:0] dabble(input logic [DigitBits-1:0] bcd,
                                                  input logic [BitsPerStep-1:0] bits);
    logic [DigitBits-1:0] acc;
    acc = bcd;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int k = 0; k < DigitSlots; k++) begin
        if (acc[4*k +: 4] >= 4'd5) begin
          acc[4*k +: 4] = acc[4*k +: 4] + 4'd3;
        end
      end
      acc = {acc[DigitBits-2:0], bits[BitsPerStep-1-s]};
    end
    return acc;
  endfunction

  // digit and operand registers
  always_comb begin
    dig_d = dig_q;
    bin_d = bin_q;
    if (ctrl_i.load) begin
      if (ctrl_i.hex) begin
        dig_d = {mag_i, {(DigitBits-64){1'b0}}};
      end else begin
        dig_d = '0;
      end
      bin_d = mag_i;
    end else if (ctrl_i.conv) begin
      dig_d = dabble(dig_q, bin_q[63 -: BitsPerStep]);
      bin_d = {bin_q[63-BitsPerStep:0], {BitsPerStep{1'b0}}};
    end else if (ctrl_i.shift) begin
      dig_d = {dig_q[DigitBits-5:0], 4'h0};
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
  end

  assign top_digit_o = dig_q[DigitBits-1 -: 4];

endmodule

`default_nettype wire

[src/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter: sequencer, magnitude logic and
// the registered output beat. Depends on i2a_pkg and i2a_digits.
`default_nettype none

// Converts one 64-bit value per input beat to ASCII text, most significant
// character first, one character per output beat, with last set on the final
// character. func selects unsigned decimal, signed decimal, hex (32 or 64 bit)
// or pointer hex with a 0x prefix; func 7 is dropped with no output. The block
// takes one value at a time and stalls its input until the last character has
// been loaded into the output register. Decimal values first pass through the
// shared binary to BCD unit, 4 bits per cycle over 64 bits, then the skip
// state drops leading zero digits, keeping at least one, before the prefix or
// minus sign and the digits go out, each held while the output is stalled; hex
// values skip the conversion and go straight to the skip state.
module integer_to_ascii_formatter (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire i2a_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output i2a_pkg::out_t     out_data_o
);
  import i2a_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [3:0] conv_q, conv_d;
  logic       neg_q, neg_d;
  logic       pfx_q, pfx_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;

  dig_ctrl_t   ctrl;
  logic [63:0] ext;
  logic [63:0] mag;
  logic        sgn;
  logic        is_hex;
  logic [3:0]  top_digit;
  logic        can_emit;

  i2a_digits u_digits (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .mag_i       (mag),
    .top_digit_o (top_digit)
  );

  // operand selection and magnitude
  always_comb begin
    ext    = in_data_i.value;
    sgn    = 1'b0;
    is_hex = 1'b0;
    unique case (in_data_i.func)
      FUNC_UDEC32: ext = {32'h0, in_data_i.value[31:0]};
      FUNC_UDEC64: ext = in_data_i.value;
      FUNC_SDEC32: begin
        ext = {{32{in_data_i.value[31]}}, in_data_i.value[31:0]};
        sgn = in_data_i.value[31];
      end
      FUNC_SDEC64: sgn = in_data_i.value[63];
      FUNC_HEX32: begin
        ext    = {32'h0, in_data_i.value[31:0]};
        is_hex = 1'b1;
      end
      FUNC_HEX64, FUNC_PTR: is_hex = 1'b1;
      default: ext = in_data_i.value;
    endcase
    mag = sgn ? (~ext + 64'd1) : ext;
  end

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    conv_d      = conv_q;
    neg_d       = neg_q;
    pfx_d       = pfx_q;
    ctrl        = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_data_i.func != FUNC_UNUSED) begin
          ctrl.load = 1'b1;
          ctrl.hex  = is_hex;
          neg_d     = sgn;
          pfx_d     = (in_data_i.func == FUNC_PTR);
          cnt_d     = is_hex ? HEX_DIGITS : DEC_DIGITS;
          conv_d    = '0;
          state_d   = is_hex ? ST_SKIP : ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        conv_d    = conv_q + 4'd1;
        if (conv_q == CONV_LAST) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (top_digit == 4'h0 && cnt_q > 5'd1) begin
          ctrl.shift = 1'b1;
          cnt_d      = cnt_q - 5'd1;
        end else if (pfx_q) begin
          state_d = ST_PFX0;
        end else if (neg_q) begin
          state_d = ST_MINUS;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_PFX0: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '{char_out: CHAR_ZERO, last: 1'b0};
          state_d     = ST_PFXX;
        end
      end
      ST_PFXX: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '{char_out: CHAR_X, last: 1'b0};
          state_d     = ST_DIGIT;
        end
      end
      ST_MINUS: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '{char_out: CHAR_MINUS, last: 1'b0};
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '{char_out: digit_char(top_digit), last: (cnt_q == 5'd1)};
          ctrl.shift  = 1'b1;
          cnt_d       = cnt_q - 5'd1;
          if (cnt_q == 5'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      conv_q      <= '0;
      neg_q       <= 1'b0;
      pfx_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      conv_q      <= conv_d;
      neg_q       <= neg_d;
      pfx_q       <= pfx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[src/i2a_checker.sv]
// Port-level checks for the integer to ASCII formatter, bound to the top level.
// Depends on i2a_pkg and integer_to_ascii_formatter.
`default_nettype none

module i2a_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire i2a_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire i2a_pkg::out_t out_data_o
);
  import i2a_pkg::*;

  // a usable value closes the input until its text is out
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.func != FUNC_UNUSED |=> in_stall_o)
    else $error("input not stalled after accepting a value");

  // the input reopens only with the last character waiting at the output
  a_reopen_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && out_data_o.last)
    else $error("input reopened without a last character beat");

  // every character is a digit, a hex letter, x or a minus sign
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.char_out >= CHAR_ZERO && out_data_o.char_out <= CHAR_NINE)
      || (out_data_o.char_out >= CHAR_A && out_data_o.char_out <= CHAR_F)
      || out_data_o.char_out == CHAR_X || out_data_o.char_out == CHAR_MINUS)
    else $error("unexpected character");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/sv/tb_integer_to_ascii_formatter.sv]
// Self-checking testbench for integer_to_ascii_formatter: random and directed values in all
// formats, characters predicted per value and checked beat by beat at the output.
// Depends on i2a_pkg and the formatter RTL.
module tb_integer_to_ascii_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  localparam string DIGIT_GLYPHS = "0123456789abcdef";
  localparam int    RANDOM_VALUES = 226;
  localparam int    DRAIN_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_t  in_data_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  in_t  pending_values[$];
  out_t expected_chars[$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   bad_beats = 0;

  integer_to_ascii_formatter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // text of one value, appended to the expected characters
  function automatic void predict_text(input in_t item);
    logic [63:0] mag;
    logic        neg;
    logic        hex;
    logic        pfx;
    logic [3:0]  nib;
    out_t        text[$];
    mag = item.value;
    neg = 1'b0;
    hex = 1'b0;
    pfx = 1'b0;
    case (item.func)
      FUNC_UDEC32: mag = {32'd0, item.value[31:0]};
      FUNC_UDEC64: ;
      FUNC_SDEC32: begin
        mag = {{32{item.value[31]}}, item.value[31:0]};
        neg = mag[63];
      end
      FUNC_SDEC64: neg = mag[63];
      FUNC_HEX32: begin
        mag = {32'd0, item.value[31:0]};
        hex = 1'b1;
      end
      FUNC_HEX64: hex = 1'b1;
      FUNC_PTR: begin
        hex = 1'b1;
        pfx = 1'b1;
      end
      default: return;
    endcase
    // two's complement magnitude, most negative value included
    if (neg) mag = -mag;
    // digits come out least significant first
    do begin
      if (hex) begin
        nib = mag[3:0];
        mag = mag >> 4;
      end else begin
        nib = 4'(mag % 64'd10);
        mag = mag / 64'd10;
      end
      text.push_front('{char_out: 7'(DIGIT_GLYPHS[nib]), last: 1'b0});
    end while (mag != 64'd0);
    if (neg) text.push_front('{char_out: CHAR_MINUS, last: 1'b0});
    if (pfx) begin
      text.push_front('{char_out: CHAR_X, last: 1'b0});
      text.push_front('{char_out: CHAR_ZERO, last: 1'b0});
    end
    text[text.size() - 1].last = 1'b1;
    foreach (text[i]) expected_chars.push_back(text[i]);
  endfunction

  task automatic queue_value(input logic [63:0] value, input logic [2:0] func);
    in_t item;
    item.value = value;
    item.func = func;
    pending_values.push_back(item);
  endtask

  // random values of random bit length, some negated; unused selectors are extra
  task automatic queue_random_batch(input int count);
    int          made;
    int unsigned width;
    logic [63:0] value;
    made = 0;
    while (made < count) begin
      width = $urandom_range(1, 64);
      value = {$urandom, $urandom} >> (64 - width);
      if ($urandom_range(0, 3) == 0) value = -value;
      if ($urandom_range(0, 11) == 0) begin
        queue_value(value, FUNC_UNUSED);
      end else begin
        queue_value(value, 3'($urandom_range(FUNC_UDEC32, FUNC_PTR)));
        made++;
      end
    end
  endtask

  task automatic wait_sent();
    while (pending_values.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  // input driver: predict on each accepted beat, then maybe present the next one
  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_text(in_data_i);
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i <= pending_values.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // output monitor: each accepted beat against the oldest expected character
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: char_out %h last %b", out_data_o.char_out, out_data_o.last);
        bad_beats++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.char_out !== want.char_out) begin
          $error("char_out: expected %h, actual %h", want.char_out, out_data_o.char_out);
          bad_beats++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_data_o.last);
          bad_beats++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // stimulus and end of run
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 22;
    recv_idle_pct = 52;

    // zero and all ones in every format
    for (int f = FUNC_UDEC32; f <= FUNC_PTR; f++) begin
      queue_value(64'd0, 3'(f));
      queue_value({64{1'b1}}, 3'(f));
    end
    // most negative values, with and without junk above bit 31
    queue_value(64'h8000_0000_0000_0000, FUNC_SDEC64);
    queue_value(64'h1234_5678_8000_0000, FUNC_SDEC32);
    // largest positive signed values
    queue_value(64'h7fff_ffff_ffff_ffff, FUNC_SDEC64);
    queue_value(64'hffff_ffff_7fff_ffff, FUNC_SDEC32);
    // 32-bit forms ignore the upper word
    queue_value(64'hdead_beef_0000_0009, FUNC_UDEC32);
    queue_value(64'hdead_beef_0000_000f, FUNC_HEX32);
    queue_value(64'h8ac7_2304_89e7_ffff, FUNC_UDEC64);
    queue_value(64'h0123_4567_89ab_cdef, FUNC_HEX64);
    queue_value(64'h0000_0000_0000_0010, FUNC_PTR);
    // unused selector produces nothing
    queue_value(64'd5, FUNC_UNUSED);

    queue_random_batch(RANDOM_VALUES / 3);
    wait_sent();

    send_idle_pct = 52;
    recv_idle_pct = 22;
    queue_random_batch(RANDOM_VALUES / 3);
    wait_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_batch(RANDOM_VALUES - 2 * (RANDOM_VALUES / 3));
    wait_sent();

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_beats == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/i2a_pkg.sv
src/i2a_digits.sv
src/integer_to_ascii_formatter.sv
src/i2a_checker.sv
tb/sv/tb_integer_to_ascii_formatter.sv
